FILE: rtl/day_night_schedule_panel_controller_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the day/night schedule panel controller
// Shared helpers; each expects clk_i and rst_ni in scope.
// ----------------------------------------------------------------------------
`ifndef DAY_NIGHT_SCHEDULE_PANEL_CONTROLLER_MACROS_SVH
`define DAY_NIGHT_SCHEDULE_PANEL_CONTROLLER_MACROS_SVH

// Condition must hold at every edge outside reset
`define DNSP_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define DNSP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/dnsp_pkg.sv
// ----------------------------------------------------------------------------
// dnsp_pkg
// Types, codes and helpers shared by the schedule panel controller.
// ----------------------------------------------------------------------------
`default_nettype none

package dnsp_pkg;

  // Request types
  localparam logic [1:0] REQ_POLL    = 2'd0;
  localparam logic [1:0] REQ_BUTTON  = 2'd1;
  localparam logic [1:0] REQ_TIMEOUT = 2'd2;

  // Button codes
  localparam logic [2:0] BTN_SELECT = 3'd0;
  localparam logic [2:0] BTN_RIGHT  = 3'd1;
  localparam logic [2:0] BTN_LEFT   = 3'd2;
  localparam logic [2:0] BTN_UP     = 3'd3;
  localparam logic [2:0] BTN_DOWN   = 3'd4;

  // Heat modes
  localparam logic [1:0] MODE_OFF   = 2'd0;
  localparam logic [1:0] MODE_DAY   = 2'd1;
  localparam logic [1:0] MODE_NIGHT = 2'd2;

  // Edit fields
  localparam logic [2:0] FIELD_VIEW      = 3'd0;
  localparam logic [2:0] FIELD_CLK_HOUR  = 3'd1;
  localparam logic [2:0] FIELD_CLK_MIN   = 3'd2;
  localparam logic [2:0] FIELD_WEEKDAY   = 3'd3;
  localparam logic [2:0] FIELD_BEGIN_HR  = 3'd4;
  localparam logic [2:0] FIELD_BEGIN_MIN = 3'd5;
  localparam logic [2:0] FIELD_END_HR    = 3'd6;
  localparam logic [2:0] FIELD_END_MIN   = 3'd7;

  // Limits and reset values
  localparam logic [4:0]  HOUR_MAX         = 5'd23;
  localparam logic [5:0]  MINUTE_MAX       = 6'd59;
  localparam logic [2:0]  WEEKDAY_MAX      = 3'd6;
  localparam logic [15:0] LONG_PRESS_RESET = 16'd3000;
  localparam logic [4:0]  BEGIN_HOUR_RESET = 5'd6;
  localparam logic [5:0]  BEGIN_MIN_RESET  = 6'd0;
  localparam logic [4:0]  END_HOUR_RESET   = 5'd22;
  localparam logic [5:0]  END_MIN_RESET    = 6'd0;

  // Queue sizes
  localparam int CmdQDepth = 2;
  localparam int CmdQPtrW  = $clog2(CmdQDepth);
  localparam int CmdQCntW  = $clog2(CmdQDepth + 1);
  localparam int ResQDepth = 2;
  localparam int ResQPtrW  = $clog2(ResQDepth);
  localparam int ResQCntW  = $clog2(ResQDepth + 1);

  // Decoded operation handed from front to back
  typedef enum logic [2:0] {
    OP_NOP,
    OP_TIMEOUT,
    OP_CLASSIFY,
    OP_SELECT,
    OP_RIGHT,
    OP_LEFT,
    OP_UP,
    OP_DOWN
  } op_e;

  typedef struct packed {
    op_e        op;
    logic       long_press;
    logic [4:0] now_hour;
    logic [5:0] now_minute;
    logic [2:0] now_weekday;
  } cmd_t;

  typedef struct packed {
    logic [1:0] heat_mode;
    logic       mode_changed;
    logic [2:0] edit_field;
    logic       clock_write;
    logic [4:0] clock_hour;
    logic [5:0] clock_minute;
    logic [2:0] clock_weekday;
    logic       schedule_write;
    logic [4:0] begin_hour;
    logic [5:0] begin_minute;
    logic [4:0] end_hour;
    logic [5:0] end_minute;
  } res_t;

  // Step a value by one, clamped to 0..top
  function automatic logic [5:0] sat_step(logic [5:0] v, logic up, logic [5:0] top);
    logic [5:0] dec;
    dec = v - 6'd1;
    if (up) begin
      sat_step = (v >= top) ? top : v + 6'd1;
    end else if (v == 6'd0) begin
      sat_step = 6'd0;
    end else begin
      sat_step = (dec > top) ? top : dec;
    end
  endfunction

endpackage

`default_nettype wire

FILE: rtl/dnsp_front.sv
// ----------------------------------------------------------------------------
// dnsp_front
// Holds the long-press threshold and decodes each input beat into a command.
// ----------------------------------------------------------------------------
`default_nettype none

module dnsp_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cfg_we_i,
  input  wire logic [15:0]   cfg_wdata_i,
  input  wire logic [1:0]    req_type_i,
  input  wire logic [2:0]    button_i,
  input  wire logic          pressed_i,
  input  wire logic [15:0]   press_duration_ms_i,
  input  wire logic [4:0]    now_hour_i,
  input  wire logic [5:0]    now_minute_i,
  input  wire logic [2:0]    now_weekday_i,
  output dnsp_pkg::cmd_t     cmd_o
);
  import dnsp_pkg::*;

  logic [15:0] long_press_q;
  op_e         op;

  // Hold the long-press threshold
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_press_q <= LONG_PRESS_RESET;
    end else if (cfg_we_i) begin
      long_press_q <= cfg_wdata_i;
    end
  end

  // Classify the request; presses and idle buttons only refresh the mode
  always_comb begin
    op = OP_NOP;
    case (req_type_i)
      REQ_POLL: op = OP_CLASSIFY;
      REQ_BUTTON: begin
        if (pressed_i) begin
          op = OP_CLASSIFY;
        end else begin
          case (button_i)
            BTN_SELECT: op = OP_SELECT;
            BTN_RIGHT:  op = OP_RIGHT;
            BTN_LEFT:   op = OP_LEFT;
            BTN_UP:     op = OP_UP;
            BTN_DOWN:   op = OP_DOWN;
            default:    op = OP_CLASSIFY;
          endcase
        end
      end
      REQ_TIMEOUT: op = OP_TIMEOUT;
      default:     op = OP_NOP;
    endcase
  end

  assign cmd_o.op          = op;
  assign cmd_o.long_press  = (press_duration_ms_i >= long_press_q);
  assign cmd_o.now_hour    = now_hour_i;
  assign cmd_o.now_minute  = now_minute_i;
  assign cmd_o.now_weekday = now_weekday_i;

endmodule

`default_nettype wire

FILE: rtl/dnsp_cmd_q.sv
// ----------------------------------------------------------------------------
// dnsp_cmd_q
// Short command queue between the decode front and the execute back.
// ----------------------------------------------------------------------------
`default_nettype none

module dnsp_cmd_q (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire dnsp_pkg::cmd_t data_i,
  output logic                full_o,
  output logic                valid_o,
  input  wire logic           pop_i,
  output dnsp_pkg::cmd_t      data_o
);
  import dnsp_pkg::*;

  cmd_t                mem_q [CmdQDepth];
  logic [CmdQPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [CmdQPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CmdQCntW-1:0] cnt_q, cnt_d;
  logic                do_push, do_pop;

  assign full_o  = (cnt_q == CmdQCntW'(CmdQDepth));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Advance pointers and count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == CmdQPtrW'(CmdQDepth - 1)) ? '0 : wr_ptr_q + CmdQPtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == CmdQPtrW'(CmdQDepth - 1)) ? '0 : rd_ptr_q + CmdQPtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CmdQCntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CmdQCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store the incoming beat
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/dnsp_back.sv
// ----------------------------------------------------------------------------
// dnsp_back
// Executes commands against the mode, editor and schedule state and queues
// one result beat per command.
// ----------------------------------------------------------------------------
`default_nettype none

`include "day_night_schedule_panel_controller_macros.svh"

module dnsp_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           cmd_valid_i,
  input  wire dnsp_pkg::cmd_t cmd_i,
  output logic                cmd_pop_o,
  output logic                empty_o,
  input  wire logic           pop_i,
  output dnsp_pkg::res_t      res_o
);
  import dnsp_pkg::*;

  logic [1:0] mode_q, mode_d;
  logic [2:0] field_q, field_d;
  logic [4:0] bh_q, bh_d;
  logic [5:0] bm_q, bm_d;
  logic [4:0] eh_q, eh_d;
  logic [5:0] em_q, em_d;

  logic       night, up, changed, cw, sw;
  logic [1:0] nmode;
  logic [4:0] ch;
  logic [5:0] cm;
  logic [2:0] cd, wday_step;
  logic [5:0] nh_step, nm_step, bh_step, bm_step, eh_step, em_step;
  res_t       res;

  res_t                res_mem_q [ResQDepth];
  logic [ResQPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [ResQCntW-1:0] cnt_q, cnt_d;
  logic                res_pop, res_full;

  // Take a command when the result queue has room or frees a slot now
  assign empty_o   = (cnt_q == '0);
  assign res_full  = (cnt_q == ResQCntW'(ResQDepth));
  assign res_pop   = pop_i && !empty_o;
  assign cmd_pop_o = cmd_valid_i && (!res_full || res_pop);
  assign res_o     = res_mem_q[rd_ptr_q];

  // Classify the current time against the day window
  assign night = (cmd_i.now_hour < bh_q) || (cmd_i.now_hour > eh_q) ||
                 ((cmd_i.now_hour == bh_q) && (cmd_i.now_minute < bm_q)) ||
                 ((cmd_i.now_hour == eh_q) && (cmd_i.now_minute > em_q));
  assign nmode = night ? MODE_NIGHT : MODE_DAY;
  assign up    = (cmd_i.op == OP_UP);

  // Candidate step values for every editable field
  assign nh_step = sat_step({1'b0, cmd_i.now_hour}, up, {1'b0, HOUR_MAX});
  assign nm_step = sat_step(cmd_i.now_minute, up, MINUTE_MAX);
  assign bh_step = sat_step({1'b0, bh_q}, up, {1'b0, HOUR_MAX});
  assign bm_step = sat_step(bm_q, up, MINUTE_MAX);
  assign eh_step = sat_step({1'b0, eh_q}, up, {1'b0, HOUR_MAX});
  assign em_step = sat_step(em_q, up, MINUTE_MAX);
  assign wday_step = up ?
      ((cmd_i.now_weekday >= WEEKDAY_MAX) ? 3'd0 : cmd_i.now_weekday + 3'd1) :
      ((cmd_i.now_weekday == 3'd0) ? WEEKDAY_MAX : cmd_i.now_weekday - 3'd1);

  // Work the mode and edit state machine
  always_comb begin
    mode_d  = mode_q;
    field_d = field_q;
    bh_d    = bh_q;
    bm_d    = bm_q;
    eh_d    = eh_q;
    em_d    = em_q;
    changed = 1'b0;
    cw      = 1'b0;
    sw      = 1'b0;
    ch      = '0;
    cm      = '0;
    cd      = '0;
    if (cmd_pop_o) begin
      case (cmd_i.op)
        OP_NOP: begin
          mode_d = mode_q;
        end
        OP_TIMEOUT: begin
          field_d = FIELD_VIEW;
        end
        default: begin
          if (nmode != mode_q) begin
            mode_d  = nmode;
            changed = 1'b1;
          end
          case (cmd_i.op)
            OP_SELECT: begin
              if (cmd_i.long_press && (field_q == FIELD_VIEW)) begin
                field_d = FIELD_CLK_HOUR;
              end else if (field_q != FIELD_VIEW) begin
                field_d = FIELD_VIEW;
              end
            end
            OP_RIGHT: begin
              if (field_q != FIELD_VIEW) begin
                field_d = (field_q == FIELD_END_MIN) ? FIELD_CLK_HOUR : field_q + 3'd1;
              end
            end
            OP_LEFT: begin
              if (field_q != FIELD_VIEW) begin
                field_d = (field_q == FIELD_CLK_HOUR) ? FIELD_END_MIN : field_q - 3'd1;
              end
            end
            OP_UP, OP_DOWN: begin
              if (field_q inside {FIELD_CLK_HOUR, FIELD_CLK_MIN, FIELD_WEEKDAY}) begin
                cw = 1'b1;
                ch = cmd_i.now_hour;
                cm = cmd_i.now_minute;
                cd = cmd_i.now_weekday;
                case (field_q)
                  FIELD_CLK_HOUR: ch = nh_step[4:0];
                  FIELD_CLK_MIN:  cm = nm_step;
                  default:        cd = wday_step;
                endcase
              end else if (field_q != FIELD_VIEW) begin
                sw = 1'b1;
                case (field_q)
                  FIELD_BEGIN_HR:  bh_d = bh_step[4:0];
                  FIELD_BEGIN_MIN: bm_d = bm_step;
                  FIELD_END_HR:    eh_d = eh_step[4:0];
                  default:         em_d = em_step;
                endcase
              end
            end
            default: begin
              field_d = field_q;
            end
          endcase
        end
      endcase
    end
  end

  // Assemble the result beat from the updated state
  always_comb begin
    res.heat_mode      = mode_d;
    res.mode_changed   = changed;
    res.edit_field     = field_d;
    res.clock_write    = cw;
    res.clock_hour     = ch;
    res.clock_minute   = cm;
    res.clock_weekday  = cd;
    res.schedule_write = sw;
    res.begin_hour     = bh_d;
    res.begin_minute   = bm_d;
    res.end_hour       = eh_d;
    res.end_minute     = em_d;
  end

  // Hold the controller state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_OFF;
      field_q <= FIELD_VIEW;
      bh_q    <= BEGIN_HOUR_RESET;
      bm_q    <= BEGIN_MIN_RESET;
      eh_q    <= END_HOUR_RESET;
      em_q    <= END_MIN_RESET;
    end else begin
      mode_q  <= mode_d;
      field_q <= field_d;
      bh_q    <= bh_d;
      bm_q    <= bm_d;
      eh_q    <= eh_d;
      em_q    <= em_d;
    end
  end

  // Count queued result beats
  always_comb begin
    cnt_d = cnt_q;
    if (cmd_pop_o && !res_pop) begin
      cnt_d = cnt_q + ResQCntW'(1);
    end else if (res_pop && !cmd_pop_o) begin
      cnt_d = cnt_q - ResQCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (cmd_pop_o) begin
        wr_ptr_q <= (wr_ptr_q == ResQPtrW'(ResQDepth - 1)) ? '0 : wr_ptr_q + ResQPtrW'(1);
      end
      if (res_pop) begin
        rd_ptr_q <= (rd_ptr_q == ResQPtrW'(ResQDepth - 1)) ? '0 : rd_ptr_q + ResQPtrW'(1);
      end
    end
  end

  // Store the result beat
  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      res_mem_q[wr_ptr_q] <= res;
    end
  end

  // Checks
  `DNSP_ASSERT_NEXT(a_mode_set_after_classify,
    cmd_pop_o && (cmd_i.op != OP_NOP) && (cmd_i.op != OP_TIMEOUT),
    (mode_q == MODE_DAY) || (mode_q == MODE_NIGHT), "mode not set after classify")
  `DNSP_ASSERT_NEXT(a_timeout_to_view, cmd_pop_o && (cmd_i.op == OP_TIMEOUT),
    field_q == FIELD_VIEW, "timeout did not return to view")
  `DNSP_ASSERT_NEXT(a_view_left_by_select_only,
    cmd_pop_o && (field_q == FIELD_VIEW) && (cmd_i.op != OP_SELECT),
    field_q == FIELD_VIEW, "view left without select")
  `DNSP_ASSERT_ALWAYS(a_schedule_in_range,
    (bh_q <= HOUR_MAX) && (eh_q <= HOUR_MAX) && (bm_q <= MINUTE_MAX) && (em_q <= MINUTE_MAX),
    "schedule out of range")

endmodule

`default_nettype wire

FILE: rtl/day_night_schedule_panel_controller.sv
// ----------------------------------------------------------------------------
// Day/night schedule panel controller
// Heating day/night switch with a five-button editing panel.
// ----------------------------------------------------------------------------
//  channel   direction  handshake              payload
//  request   in         push / full            req_type .. now_weekday
//  result    out        pop / empty            heat_mode .. end_minute_out
//  config    in         cfg_we_i (no wait)     cfg_wdata_i = long_press_ms
//
//  One request beat per cycle is sustained while results are popped. A taken
//  request is registered in the command queue; the back stage runs it once
//  the result queue has room and queues its result beat for the result ports.
//  Both queues hold two beats, so a stalled result side raises full after
//  four beats. Reset clears the queues, mode (off), edit field (view),
//  the day window (06:00 to 22:00) and the long-press threshold (3000 ms).
// ----------------------------------------------------------------------------
`default_nettype none

module day_night_schedule_panel_controller (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i,
  input  wire logic        push,
  output logic             full,
  input  wire logic [1:0]  req_type_i,
  input  wire logic [2:0]  button_i,
  input  wire logic        pressed_i,
  input  wire logic [15:0] press_duration_ms_i,
  input  wire logic [4:0]  now_hour_i,
  input  wire logic [5:0]  now_minute_i,
  input  wire logic [2:0]  now_weekday_i,
  output logic             empty,
  input  wire logic        pop,
  output logic [1:0]       heat_mode_o,
  output logic             mode_changed_o,
  output logic [2:0]       edit_field_o,
  output logic             clock_write_o,
  output logic [4:0]       clock_hour_o,
  output logic [5:0]       clock_minute_o,
  output logic [2:0]       clock_weekday_o,
  output logic             schedule_write_o,
  output logic [4:0]       begin_hour_out_o,
  output logic [5:0]       begin_minute_out_o,
  output logic [4:0]       end_hour_out_o,
  output logic [5:0]       end_minute_out_o
);
  import dnsp_pkg::*;

  cmd_t front_cmd, q_cmd;
  res_t res;
  logic q_valid, q_pop;

  dnsp_front u_front (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_wdata_i,
    .req_type_i,
    .button_i,
    .pressed_i,
    .press_duration_ms_i,
    .now_hour_i,
    .now_minute_i,
    .now_weekday_i,
    .cmd_o (front_cmd)
  );

  dnsp_cmd_q u_cmd_q (
    .clk_i,
    .rst_ni,
    .push_i  (push),
    .data_i  (front_cmd),
    .full_o  (full),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .data_o  (q_cmd)
  );

  dnsp_back u_back (
    .clk_i,
    .rst_ni,
    .cmd_valid_i (q_valid),
    .cmd_i       (q_cmd),
    .cmd_pop_o   (q_pop),
    .empty_o     (empty),
    .pop_i       (pop),
    .res_o       (res)
  );

  // Unpack the result beat
  assign heat_mode_o        = res.heat_mode;
  assign mode_changed_o     = res.mode_changed;
  assign edit_field_o       = res.edit_field;
  assign clock_write_o      = res.clock_write;
  assign clock_hour_o       = res.clock_hour;
  assign clock_minute_o     = res.clock_minute;
  assign clock_weekday_o    = res.clock_weekday;
  assign schedule_write_o   = res.schedule_write;
  assign begin_hour_out_o   = res.begin_hour;
  assign begin_minute_out_o = res.begin_minute;
  assign end_hour_out_o     = res.end_hour;
  assign end_minute_out_o   = res.end_minute;

endmodule

`default_nettype wire
